@@ hdl/olfoc_pkg.sv @@
// ----------------------------------------------------------------------------
// olfoc_pkg
// shared types, register codes and fixed-point constants of the open loop
// sine pwm duty block
// ----------------------------------------------------------------------------
`default_nettype none

package olfoc_pkg;

  // interval handling
  localparam int unsigned MAX_INTERVAL_US   = 500000;
  localparam int unsigned SUBST_INTERVAL_US = 1000;
  localparam int DT_W = $clog2(MAX_INTERVAL_US + 1);

  // shaft increment: |v| * dt * gain, then scaled down by 2^24, rounding half up
  localparam int MAG_W  = 16;
  localparam int P1_W   = MAG_W + DT_W;
  localparam int GAIN_W = 26;
  localparam logic [GAIN_W-1:0] VEL_GAIN_Q24 = 26'd44801102;
  localparam int LO_W   = 18;
  localparam int HI_W   = P1_W - LO_W;
  localparam int SUM_W  = P1_W + GAIN_W;
  localparam int INC_LSB = 24;

  // sine table generation and phase arithmetic
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam logic [16:0] SQRT3_Q16 = 17'd113512;
  localparam logic [14:0] SINE_AMP  = 15'd32767;
  localparam int ALPHA_W = 33;
  localparam int MID_W   = 31;
  localparam int SB_W    = 51;
  localparam int PH_W    = 52;
  localparam int DEN_W   = 48;
  localparam int NUM_W   = 56;

  // configuration port
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_VELOCITY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_VOLTAGE   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SUPPLY_VOLTAGE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ZERO_OFFSET     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POLE_PAIR_COUNT = 3'd4;

  localparam logic [15:0] RST_TARGET_VELOCITY = 16'd804;
  localparam logic [15:0] RST_DRIVE_VOLTAGE   = 16'd6300;
  localparam logic [15:0] RST_SUPPLY_VOLTAGE  = 16'd12600;
  localparam logic [15:0] RST_ZERO_OFFSET     = 16'd0;
  localparam logic [4:0]  RST_POLE_PAIR_COUNT = 5'd1;

  typedef struct packed {
    logic signed [15:0] target_velocity;
    logic [15:0]        drive_voltage;
    logic [15:0]        supply_voltage;
    logic [15:0]        zero_offset;
    logic [4:0]         pole_pair_count;
  } cfg_t;

  // classified tick as it travels through the queue
  typedef struct packed {
    logic [DT_W-1:0] dt;
    logic            replaced;
  } item_t;

  // sin(x) on the quarter wave, x and result in q30
  function automatic longint quarter_sin(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = ((x * x2) >>> 30) / 6;
    sum  = x - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 210;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 272;
    sum  = sum + term;
    return sum;
  endfunction

endpackage

`default_nettype wire

@@ hdl/open_loop_foc_sine_pwm_duty.sv @@
// ----------------------------------------------------------------------------
// open_loop_foc_sine_pwm_duty
// open loop sine pwm: shaft angle integration, inverse park and clarke,
// three-phase duty compare values
// ----------------------------------------------------------------------------
// the back takes one item at a time: the angle and phase sequencer, then the
//   8-step restoring divider that runs the three phases side by side; the next
//   item is taken from the queue only once the result is in the output register
// a two-entry queue lets the front take up to two further ticks meanwhile
// reset (rst, synchronous): registers to defaults, shaft angle and last
//   timestamp to zero, queue and output emptied
`default_nettype none

module open_loop_foc_sine_pwm_duty #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  // tick channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   now_us,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    duty_a,
  output logic [7:0]                    duty_b,
  output logic [7:0]                    duty_c,
  output logic [15:0]                   electrical_angle,
  output logic                          interval_replaced,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [olfoc_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  olfoc_pkg::cfg_t   cfg;
  olfoc_pkg::item_t  push_item;
  olfoc_pkg::item_t  pop_item;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_not_empty;
  logic              wr_en;
  logic [olfoc_pkg::REG_IDX_W-1:0] reg_idx;

  // ---------------------------------------------------------------------------
  // register file: word addressed, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[olfoc_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_velocity <= $signed(olfoc_pkg::RST_TARGET_VELOCITY);
      cfg.drive_voltage   <= olfoc_pkg::RST_DRIVE_VOLTAGE;
      cfg.supply_voltage  <= olfoc_pkg::RST_SUPPLY_VOLTAGE;
      cfg.zero_offset     <= olfoc_pkg::RST_ZERO_OFFSET;
      cfg.pole_pair_count <= olfoc_pkg::RST_POLE_PAIR_COUNT;
    end else if (wr_en) begin
      case (reg_idx)
        olfoc_pkg::REG_TARGET_VELOCITY: cfg.target_velocity <= $signed(pwdata[15:0]);
        olfoc_pkg::REG_DRIVE_VOLTAGE:   cfg.drive_voltage   <= pwdata[15:0];
        olfoc_pkg::REG_SUPPLY_VOLTAGE:  cfg.supply_voltage  <= pwdata[15:0];
        olfoc_pkg::REG_ZERO_OFFSET:     cfg.zero_offset     <= pwdata[15:0];
        olfoc_pkg::REG_POLE_PAIR_COUNT: cfg.pole_pair_count <= pwdata[4:0];
        default: begin
          // unmapped word, write dropped
        end
      endcase
    end
  end

  // read back, values zero extended
  always_comb begin
    case (reg_idx)
      olfoc_pkg::REG_TARGET_VELOCITY: prdata = {16'h0000, cfg.target_velocity};
      olfoc_pkg::REG_DRIVE_VOLTAGE:   prdata = {16'h0000, cfg.drive_voltage};
      olfoc_pkg::REG_SUPPLY_VOLTAGE:  prdata = {16'h0000, cfg.supply_voltage};
      olfoc_pkg::REG_ZERO_OFFSET:     prdata = {16'h0000, cfg.zero_offset};
      olfoc_pkg::REG_POLE_PAIR_COUNT: prdata = {27'h0000000, cfg.pole_pair_count};
      default:                        prdata = 32'h0000_0000;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: interval measurement and substitution of zero or long intervals
  // ---------------------------------------------------------------------------
  olfoc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .now_us     (now_us),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  // ---------------------------------------------------------------------------
  // queue between front and sequencer
  // ---------------------------------------------------------------------------
  olfoc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_not_empty)
  );

  // ---------------------------------------------------------------------------
  // back: shaft angle, electrical angle, sine lookup, transforms, duty divide,
  // output register
  // ---------------------------------------------------------------------------
  olfoc_back #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_valid           (queue_not_empty),
    .q_item            (pop_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .duty_a            (duty_a),
    .duty_b            (duty_b),
    .duty_c            (duty_c),
    .electrical_angle  (electrical_angle),
    .interval_replaced (interval_replaced)
  );

endmodule

`default_nettype wire

@@ hdl/olfoc_front.sv @@
// ----------------------------------------------------------------------------
// olfoc_front
// takes ticks, measures the interval and substitutes bad intervals
// ----------------------------------------------------------------------------
`default_nettype none

module olfoc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        now_us,
  output logic               push,
  output olfoc_pkg::item_t   push_item,
  input  logic               queue_full
);

  localparam int DtW = olfoc_pkg::DT_W;

  logic [31:0] previous_time;
  logic [31:0] interval;
  logic        replaced;

  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  // modular difference gives the true interval across a timestamp wrap
  assign interval = now_us - previous_time;
  assign replaced = (interval == '0) ||
                    (interval > 32'(olfoc_pkg::MAX_INTERVAL_US));

  always_comb begin
    push_item.replaced = replaced;
    push_item.dt = replaced ? DtW'(olfoc_pkg::SUBST_INTERVAL_US) : interval[DtW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
    end else if (push) begin
      previous_time <= now_us;
    end
  end

endmodule

`default_nettype wire

@@ hdl/olfoc_queue.sv @@
// ----------------------------------------------------------------------------
// olfoc_queue
// two-entry queue between the tick front end and the duty sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module olfoc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  olfoc_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output olfoc_pkg::item_t pop_item,
  output logic             not_empty
);

  localparam logic [1:0] Depth = 2'd2;

  olfoc_pkg::item_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == Depth);
  assign not_empty = (count != 2'd0);
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("queue written while full");
`endif

endmodule

`default_nettype wire

@@ hdl/olfoc_back.sv @@
// ----------------------------------------------------------------------------
// olfoc_back
// duty sequencer: shaft angle, sine rom, inverse park and clarke, divider
// ----------------------------------------------------------------------------
`default_nettype none

module olfoc_back #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  olfoc_pkg::cfg_t    cfg,
  input  logic               q_valid,
  input  olfoc_pkg::item_t   q_item,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         duty_a,
  output logic [7:0]         duty_b,
  output logic [7:0]         duty_c,
  output logic [15:0]        electrical_angle,
  output logic               interval_replaced
);

  localparam int DtW   = olfoc_pkg::DT_W;
  localparam int P1W   = olfoc_pkg::P1_W;
  localparam int LoW   = olfoc_pkg::LO_W;
  localparam int HiW   = olfoc_pkg::HI_W;
  localparam int GainW = olfoc_pkg::GAIN_W;
  localparam int SumW  = olfoc_pkg::SUM_W;
  localparam int PhW   = olfoc_pkg::PH_W;
  localparam int DenW  = olfoc_pkg::DEN_W;
  localparam int NumW  = olfoc_pkg::NUM_W;
  localparam int AlW   = olfoc_pkg::ALPHA_W;
  localparam int MidW  = olfoc_pkg::MID_W;
  localparam int SbW   = olfoc_pkg::SB_W;
  localparam int IdxW  = $clog2(SINE_TABLE_DEPTH);
  localparam int DepW  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int ProdW = 16 + DepW;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_VEL     = 4'd1;
  localparam logic [3:0] S_GAIN_LO = 4'd2;
  localparam logic [3:0] S_GAIN_HI = 4'd3;
  localparam logic [3:0] S_SHAFT   = 4'd4;
  localparam logic [3:0] S_ELEC    = 4'd5;
  localparam logic [3:0] S_INDEX   = 4'd6;
  localparam logic [3:0] S_ROM     = 4'd7;
  localparam logic [3:0] S_PARK    = 4'd8;
  localparam logic [3:0] S_CLARKE  = 4'd9;
  localparam logic [3:0] S_PHASE   = 4'd10;
  localparam logic [3:0] S_LOAD    = 4'd11;
  localparam logic [3:0] S_DIV     = 4'd12;
  localparam logic [3:0] S_DONE    = 4'd13;

  // sine rom, q15 amplitude 32767, built from the quarter-wave series
  function automatic logic [SINE_TABLE_DEPTH*16-1:0] build_rom();
    logic [SINE_TABLE_DEPTH*16-1:0] rom;
    longint q;
    longint r;
    longint x;
    longint s;
    longint v;
    rom = '0;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      q = (4 * longint'(i)) / SINE_TABLE_DEPTH;
      r = 4 * longint'(i) - q * SINE_TABLE_DEPTH;
      x = (r * olfoc_pkg::HALF_PI_Q30) / SINE_TABLE_DEPTH;
      if (q[0]) begin
        s = olfoc_pkg::quarter_sin(olfoc_pkg::HALF_PI_Q30 - x);
      end else begin
        s = olfoc_pkg::quarter_sin(x);
      end
      if (s < 0) begin
        s = 0;
      end
      v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) begin
        v = 32767;
      end
      if (q >= 2) begin
        v = -v;
      end
      rom[i*16 +: 16] = v[15:0];
    end
    return rom;
  endfunction

  localparam logic [SINE_TABLE_DEPTH*16-1:0] SineRom = build_rom();

  logic [3:0]                state;
  logic [31:0]               shaft_phase;
  logic [2:0]                bit_cnt;

  logic [DtW-1:0]            dt;
  logic                      rep;
  logic [P1W-1:0]            p1;
  logic [LoW+GainW-1:0]      pp_lo;
  logic [HiW+GainW-1:0]      pp_hi;
  logic [15:0]               el;
  logic [IdxW-1:0]           idx;
  logic [IdxW-1:0]           cidx;
  logic signed [15:0]        sin_v;
  logic signed [15:0]        cos_v;
  logic signed [AlW-1:0]     alpha;
  logic signed [AlW-1:0]     beta;
  logic [MidW-1:0]           mid;
  logic signed [SbW-1:0]     sb;
  logic signed [PhW-1:0]     u_ph [3];
  logic [DenW-1:0]           den;
  logic [NumW-1:0]           rem  [3];
  logic [NumW-1:0]           dsh;
  logic [7:0]                quot [3];
  logic [2:0]                lane_zero;
  logic [2:0]                lane_full;

  logic                      load_out;
  logic [16:0]               vel_ext;
  logic [16:0]               mag17;
  logic [SumW-1:0]           inc_sum;
  logic [31:0]               inc;
  logic [31:0]               el32;
  logic [ProdW-1:0]          idx_prod;
  logic [IdxW-1:0]           idx_next;
  logic [IdxW:0]             cidx_sum;
  logic signed [16:0]        vq_s;
  logic signed [AlW-1:0]     prod_s;
  logic signed [PhW-1:0]     alpha_x;
  logic signed [PhW-1:0]     sb_x;
  logic signed [PhW-1:0]     mid_x;

  assign pop      = (state == S_IDLE) && q_valid;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // velocity magnitude, -32768 maps onto 32768
  assign vel_ext = {cfg.target_velocity[15], cfg.target_velocity};
  assign mag17   = cfg.target_velocity[15] ? (17'd0 - vel_ext) : vel_ext;

  // round half up on the magnitude, keep 32 bits of the increment
  assign inc_sum = SumW'(pp_lo) + (SumW'(pp_hi) << LoW) + (SumW'(1) << (olfoc_pkg::INC_LSB - 1));
  assign inc     = inc_sum[olfoc_pkg::INC_LSB +: 32];

  assign el32 = 32'(shaft_phase * 32'(cfg.pole_pair_count)) + {cfg.zero_offset, 16'h0000};

  assign idx_prod = ProdW'(el) * ProdW'(SINE_TABLE_DEPTH);
  assign idx_next = idx_prod[16 +: IdxW];
  assign cidx_sum = (IdxW+1)'(idx_next) + (IdxW+1)'(SINE_TABLE_DEPTH / 4);

  assign vq_s    = $signed({1'b0, cfg.drive_voltage});
  assign prod_s  = vq_s * sin_v;
  assign alpha_x = PhW'(alpha);
  assign sb_x    = PhW'(sb);
  assign mid_x   = $signed({{(PhW-MidW-16){1'b0}}, mid, 16'h0000});

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      shaft_phase <= '0;
      bit_cnt     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_VEL;
          end
        end
        S_VEL:     state <= S_GAIN_LO;
        S_GAIN_LO: state <= S_GAIN_HI;
        S_GAIN_HI: state <= S_SHAFT;
        S_SHAFT: begin
          if (cfg.target_velocity[15]) begin
            shaft_phase <= shaft_phase - inc;
          end else begin
            shaft_phase <= shaft_phase + inc;
          end
          state <= S_ELEC;
        end
        S_ELEC:   state <= S_INDEX;
        S_INDEX:  state <= S_ROM;
        S_ROM:    state <= S_PARK;
        S_PARK:   state <= S_CLARKE;
        S_CLARKE: state <= S_PHASE;
        S_PHASE:  state <= S_LOAD;
        S_LOAD: begin
          bit_cnt <= 3'd7;
          state   <= S_DIV;
        end
        S_DIV: begin
          bit_cnt <= bit_cnt - 3'd1;
          if (bit_cnt == 3'd0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        dt  <= q_item.dt;
        rep <= q_item.replaced;
      end
      S_VEL:     p1    <= P1W'(mag17[15:0]) * P1W'(dt);
      S_GAIN_LO: pp_lo <= (LoW+GainW)'(p1[LoW-1:0]) * (LoW+GainW)'(olfoc_pkg::VEL_GAIN_Q24);
      S_GAIN_HI: pp_hi <= (HiW+GainW)'(p1[P1W-1:LoW]) * (HiW+GainW)'(olfoc_pkg::VEL_GAIN_Q24);
      S_ELEC:    el    <= el32[31:16];
      S_INDEX: begin
        idx <= idx_next;
        if (cidx_sum >= (IdxW+1)'(SINE_TABLE_DEPTH)) begin
          cidx <= IdxW'(cidx_sum - (IdxW+1)'(SINE_TABLE_DEPTH));
        end else begin
          cidx <= cidx_sum[IdxW-1:0];
        end
      end
      S_ROM: begin
        sin_v <= $signed(SineRom[{idx, 4'b0000} +: 16]);
        cos_v <= $signed(SineRom[{cidx, 4'b0000} +: 16]);
      end
      S_PARK: begin
        alpha <= -prod_s;
        beta  <= vq_s * cos_v;
        mid   <= MidW'(cfg.supply_voltage) * MidW'(olfoc_pkg::SINE_AMP);
      end
      S_CLARKE: sb <= $signed({1'b0, olfoc_pkg::SQRT3_Q16}) * beta;
      S_PHASE: begin
        u_ph[0] <= (alpha_x <<< 17) + mid_x;
        u_ph[1] <= sb_x - (alpha_x <<< 16) + mid_x;
        u_ph[2] <= mid_x - (alpha_x <<< 16) - sb_x;
        den     <= {mid, 17'h00000};
      end
      S_LOAD: begin
        // clamp flags, numerator 255 * u for the in-range case
        for (int l = 0; l < 3; l++) begin
          lane_zero[l] <= u_ph[l][PhW-1] || (u_ph[l] == '0) || (den == '0);
          lane_full[l] <= u_ph[l] >= $signed({{(PhW-DenW){1'b0}}, den});
          rem[l]       <= {u_ph[l][DenW-1:0], 8'h00} - NumW'(u_ph[l][DenW-1:0]);
          quot[l]      <= '0;
        end
        dsh <= {1'b0, den, 7'h00};
      end
      S_DIV: begin
        // one quotient bit per lane each cycle
        for (int l = 0; l < 3; l++) begin
          if (rem[l] >= dsh) begin
            rem[l]           <= rem[l] - dsh;
            quot[l][bit_cnt] <= 1'b1;
          end
        end
        dsh <= dsh >> 1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      duty_a            <= lane_zero[0] ? 8'h00 : (lane_full[0] ? 8'hFF : quot[0]);
      duty_b            <= lane_zero[1] ? 8'h00 : (lane_full[1] ? 8'hFF : quot[1]);
      duty_c            <= lane_zero[2] ? 8'h00 : (lane_full[2] ? 8'hFF : quot[2]);
      electrical_angle  <= el;
      interval_replaced <= rep;
    end
  end

`ifndef SYNTHESIS
  a_shaft_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_SHAFT) |=> $stable(shaft_phase))
    else $error("shaft phase moved outside its update step");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) |=> (state == S_DIV && bit_cnt == 3'd7))
    else $error("divider did not start at the top bit");
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !lane_zero[0] && !lane_full[0]) |-> (quot[0] != 8'hFF))
    else $error("in-range phase a gave full-scale quotient");
`endif

endmodule

`default_nettype wire

@@ tb/tb_open_loop_foc_sine_pwm_duty.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_open_loop_foc_sine_pwm_duty
// self-checking bench for the open loop sine pwm duty block: timestamp ticks
// go in, each item is predicted by an in-bench rotor and inverse park/clarke
// model, and every result item is compared field by field in order
// ----------------------------------------------------------------------------
module tb_open_loop_foc_sine_pwm_duty;
  import olfoc_pkg::*;

  localparam int TABLE_DEPTH   = 1024;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 25;
  localparam int PHASE_ITEMS   = 105;
  localparam int PHASE_COUNT   = 6;
  localparam int CALM_ITEMS    = 100;
  localparam int PRINT_CAP     = 100;

  // one result item as the block presents it
  typedef struct packed {
    logic [7:0]  duty_a;
    logic [7:0]  duty_b;
    logic [7:0]  duty_c;
    logic [15:0] angle;
    logic        replaced;
  } phase_duty_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  // directed script: a tick, optionally with its result typed in, or a write
  typedef struct {
    row_kind_e             kind;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic [31:0]           value;
    bit                    pinned;
    phase_duty_t           pinned_res;
  } script_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports, every input known from time zero
  logic                in_valid  = 1'b0;
  logic                in_stall;
  logic [31:0]         now_us    = 32'h0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          duty_a;
  logic [7:0]          duty_b;
  logic [7:0]          duty_c;
  logic [15:0]         electrical_angle;
  logic                interval_replaced;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [ADDR_W-1:0]   paddr     = '0;
  logic [31:0]         pwdata    = 32'h0;
  logic [31:0]         prdata;
  logic                pready;

  open_loop_foc_sine_pwm_duty #(
    .SINE_TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .now_us(now_us),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .duty_a(duty_a),
    .duty_b(duty_b),
    .duty_c(duty_c),
    .electrical_angle(electrical_angle),
    .interval_replaced(interval_replaced),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // ---------------------------------------------------------------------------
  // predictor state: shadow registers, rotor angle, last timestamp, sine table
  // ---------------------------------------------------------------------------
  cfg_t        drive_cfg;
  logic [31:0] rotor_phase;
  logic [31:0] last_stamp;
  int          sine_q15 [TABLE_DEPTH];

  phase_duty_t duty_queue [$];   // expected result items, oldest first

  int  mismatches   = 0;
  int  results_seen = 0;
  int  cycles       = 0;
  int  gap_pct      = 0;         // chance of a sender pause after an item
  int  stall_pct    = 0;         // chance of a receiver stall burst
  int  stall_run    = 0;
  bit  calm         = 1'b0;      // closing stretch, no idling on either side

  // taylor series for sin on the quarter wave, q30 in and out
  function automatic longint taylor_quarter_sine(input longint x);
    longint x2;
    longint term;
    longint acc;
    x2   = (x * x) >>> 30;
    term = x;
    acc  = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  // table built from the quarter wave, mirrored and negated per quadrant
  initial begin : build_sine
    longint quad;
    longint rem;
    longint x;
    longint s;
    longint v;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      quad = (4 * i) / TABLE_DEPTH;
      rem  = 4 * i - quad * TABLE_DEPTH;
      x    = (rem * HALF_PI_Q30) / TABLE_DEPTH;
      s    = (quad % 2 == 1) ? taylor_quarter_sine(HALF_PI_Q30 - x) : taylor_quarter_sine(x);
      if (s < 0) s = 0;
      v = (s * 32767 + (64'sd1 <<< 29)) >>> 30;
      if (v > 32767) v = 32767;
      sine_q15[i] = (quad >= 2) ? -v : v;
    end
  end

  // fraction of the supply, clamped, scaled to an 8-bit compare value
  function automatic logic [7:0] duty_of(input longint num, input longint den);
    if (den <= 0 || num <= 0) return 8'd0;
    if (num >= den) return 8'd255;
    return 8'((num * 255) / den);
  endfunction

  // advance the rotor by one tick and work out the three duties
  function automatic phase_duty_t predict_duty(input logic [31:0] stamp);
    phase_duty_t r;
    logic [31:0] dt;
    logic [31:0] el32;
    logic [63:0] mag;
    logic [63:0] inc;
    int          vel;
    int          idx;
    int          cidx;
    longint      s, c, vq, vs, sq3, amp;
    longint      alpha, beta, mid, den, ua, ub, uc;
    dt = stamp - last_stamp;
    // a zero or overlong interval falls back to the substitute interval
    r.replaced = (dt == 0) || (dt > MAX_INTERVAL_US);
    if (r.replaced) dt = SUBST_INTERVAL_US;
    vel = drive_cfg.target_velocity;
    mag = (vel < 0) ? 64'(-vel) : 64'(vel);
    // |v| * dt * gain, rounded on the magnitude, then applied with the sign
    inc = (mag * 64'(dt) * 64'(VEL_GAIN_Q24) + 64'd8388608) >> 24;
    rotor_phase = (vel < 0) ? rotor_phase - inc[31:0] : rotor_phase + inc[31:0];
    last_stamp  = stamp;
    el32 = rotor_phase * 32'(drive_cfg.pole_pair_count) + {drive_cfg.zero_offset, 16'h0000};
    r.angle = el32[31:16];
    idx  = ((int'(r.angle) * TABLE_DEPTH) >>> 16) % TABLE_DEPTH;
    cidx = (idx + TABLE_DEPTH / 4) % TABLE_DEPTH;
    s    = sine_q15[idx];
    c    = sine_q15[cidx];
    vq   = longint'(drive_cfg.drive_voltage);
    vs   = longint'(drive_cfg.supply_voltage);
    sq3  = longint'(SQRT3_Q16);
    amp  = longint'(SINE_AMP);
    // inverse park with ud = 0, then inverse clarke, all scaled to integers
    alpha = -vq * s;
    beta  = vq * c;
    mid   = 65536 * amp * vs;
    den   = 2 * mid;
    ua = 2 * 65536 * alpha + mid;
    ub = sq3 * beta - 65536 * alpha + mid;
    uc = -65536 * alpha - sq3 * beta + mid;
    r.duty_a = duty_of(ua, den);
    r.duty_b = duty_of(ub, den);
    r.duty_c = duty_of(uc, den);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic flag_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("mismatch %s: expected %0d, got %0d (result item %0d, t=%0t)",
               what, want, got, results_seen, $time);
  endtask

  always @(posedge clk) begin : result_check
    phase_duty_t want;
    phase_duty_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {duty_a, duty_b, duty_c, electrical_angle, interval_replaced};
      if (duty_queue.size() == 0) begin
        flag_mismatch("result item with none outstanding", 0, 0);
      end else begin
        want = duty_queue.pop_front();
        if (got.duty_a !== want.duty_a) flag_mismatch("duty_a", want.duty_a, got.duty_a);
        if (got.duty_b !== want.duty_b) flag_mismatch("duty_b", want.duty_b, got.duty_b);
        if (got.duty_c !== want.duty_c) flag_mismatch("duty_c", want.duty_c, got.duty_c);
        if (got.angle !== want.angle)
          flag_mismatch("electrical_angle", want.angle, got.angle);
        if (got.replaced !== want.replaced)
          flag_mismatch("interval_replaced", want.replaced, got.replaced);
      end
      results_seen++;
    end
  end

  // receiver: random stall bursts, free runs in between
  always @(posedge clk) begin : stall_pattern
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run = stall_run - 1;
    end else if ($urandom_range(1, 100) <= stall_pct) begin
      out_stall <= 1'b1;
      stall_run = $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
      stall_run = $urandom_range(0, 15);
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("open_loop_foc_sine_pwm_duty verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // offer one item and hold it until taken; valid stays high on return
  task automatic send_tick(input logic [31:0] stamp, input bit pinned,
                           input phase_duty_t pinned_res);
    phase_duty_t want;
    in_valid <= 1'b1;
    now_us   <= stamp;
    do @(posedge clk); while (in_stall);
    want = predict_duty(stamp);
    if (pinned) want = pinned_res;
    duty_queue.push_back(want);
  endtask

  task automatic pause_sender(input int gap);
    in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // drop valid, wait for every outstanding result, then let the pipe settle
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (duty_queue.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // setup cycle then access cycle, shadow copy updated once written
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TARGET_VELOCITY: drive_cfg.target_velocity = value;
      REG_DRIVE_VOLTAGE:   drive_cfg.drive_voltage   = value;
      REG_SUPPLY_VOLTAGE:  drive_cfg.supply_voltage  = value;
      REG_ZERO_OFFSET:     drive_cfg.zero_offset     = value;
      REG_POLE_PAIR_COUNT: drive_cfg.pole_pair_count = value[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // next timestamp: mostly ordinary intervals, plus every interval corner
  function automatic logic [31:0] next_stamp(input logic [31:0] prev);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return prev + $urandom_range(1, 2000);
    if (pick < 72) return prev + $urandom_range(2001, MAX_INTERVAL_US - 1);
    if (pick < 77) return prev;                              // repeated stamp
    if (pick < 81) return prev + MAX_INTERVAL_US;            // longest accepted
    if (pick < 85) return prev + MAX_INTERVAL_US + 1;        // just too long
    if (pick < 93) return $urandom();                        // arbitrary jump
    return 32'hFFFF_FFFF - $urandom_range(0, 1500);          // just short of wrap
  endfunction

  // fresh settings for a phase, every register written
  task automatic shuffle_settings();
    logic [15:0] vel;
    logic [15:0] supply;
    logic [15:0] drive;
    logic [4:0]  poles;
    case ($urandom_range(0, 9))
      0: vel = 16'h8000;
      1: vel = 16'h7FFF;
      2: vel = 16'h0000;
      3: vel = $urandom_range(0, 1) ? 16'($urandom_range(0, 2000))
                                    : -16'($urandom_range(0, 2000));
      default: vel = $urandom();
    endcase
    case ($urandom_range(0, 19))
      0: supply = 16'd0;
      1: supply = 16'hFFFF;
      2: supply = 16'd1;
      default: supply = $urandom_range(1, 65535);
    endcase
    case ($urandom_range(0, 9))
      0: drive = 16'd0;
      1: drive = 16'hFFFF;
      2, 3, 4, 5, 6: drive = $urandom_range(0, supply);
      default: drive = $urandom();
    endcase
    poles = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 16)) : 5'($urandom_range(0, 31));
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_TARGET_VELOCITY, vel);
    write_reg(REG_DRIVE_VOLTAGE, drive);
    write_reg(REG_SUPPLY_VOLTAGE, supply);
    write_reg(REG_ZERO_OFFSET, $urandom());
    write_reg(REG_POLE_PAIR_COUNT, {11'h000, poles});
  endtask

  function automatic script_row_t tick_row(input logic [31:0] stamp);
    script_row_t r;
    r.kind       = ROW_TICK;
    r.reg_idx    = '0;
    r.value      = stamp;
    r.pinned     = 1'b0;
    r.pinned_res = '0;
    return r;
  endfunction

  function automatic script_row_t pinned_row(input logic [31:0] stamp, input logic [7:0] a,
                                             input logic [7:0] b, input logic [7:0] c,
                                             input logic [15:0] ang, input logic rep);
    script_row_t r;
    r            = tick_row(stamp);
    r.pinned     = 1'b1;
    r.pinned_res = {a, b, c, ang, rep};
    return r;
  endfunction

  function automatic script_row_t write_row(input logic [REG_IDX_W-1:0] idx,
                                            input logic [15:0] value);
    script_row_t r;
    r         = tick_row(32'h0);
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.value   = {16'h0000, value};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    script_row_t script [$];
    row_kind_e   prev_kind;

    // shadow state matches the block after reset
    drive_cfg.target_velocity = RST_TARGET_VELOCITY;
    drive_cfg.drive_voltage   = RST_DRIVE_VOLTAGE;
    drive_cfg.supply_voltage  = RST_SUPPLY_VOLTAGE;
    drive_cfg.zero_offset     = RST_ZERO_OFFSET;
    drive_cfg.pole_pair_count = RST_POLE_PAIR_COUNT;
    rotor_phase = 32'h0;
    last_stamp  = 32'h0;

    // first tick after reset: zero interval, substitute 1000 us, angle index 0
    script.push_back(pinned_row(32'h0000_0000, 8'd127, 8'd237, 8'd17, 16'd32, 1'b1));
    script.push_back(tick_row(32'd1000));
    script.push_back(tick_row(32'd1000));                 // repeated stamp
    script.push_back(tick_row(32'd501001));               // one past the limit
    script.push_back(tick_row(32'd1001001));              // exactly the limit
    script.push_back(tick_row(32'hFFFF_FF00));            // huge jump
    script.push_back(tick_row(32'h0000_0100));            // stamp wraps
    // zero pole pairs pin the angle to the offset, so duties read straight off
    script.push_back(write_row(REG_POLE_PAIR_COUNT, 16'd0));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'h0000));
    script.push_back(pinned_row(32'h0000_0300, 8'd127, 8'd237, 8'd17, 16'h0000, 1'b0));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'h4000));
    script.push_back(pinned_row(32'h0000_0301, 8'd0, 8'd191, 8'd191, 16'h4000, 1'b0));
    // zero supply gives all duties zero
    script.push_back(write_row(REG_SUPPLY_VOLTAGE, 16'd0));
    script.push_back(pinned_row(32'h0000_0302, 8'd0, 8'd0, 8'd0, 16'h4000, 1'b0));
    // tiny supply with full drive saturates both ways
    script.push_back(write_row(REG_SUPPLY_VOLTAGE, 16'd1));
    script.push_back(write_row(REG_DRIVE_VOLTAGE, 16'hFFFF));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'h0000));
    script.push_back(pinned_row(32'h0000_0303, 8'd127, 8'd255, 8'd0, 16'h0000, 1'b0));
    // no drive sits every phase at mid supply
    script.push_back(write_row(REG_DRIVE_VOLTAGE, 16'd0));
    script.push_back(write_row(REG_SUPPLY_VOLTAGE, 16'hFFFF));
    script.push_back(pinned_row(32'h0000_0304, 8'd127, 8'd127, 8'd127, 16'h0000, 1'b0));
    // full reverse speed, widest pole field, top offset
    script.push_back(write_row(REG_TARGET_VELOCITY, 16'h8000));
    script.push_back(write_row(REG_POLE_PAIR_COUNT, 16'd31));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'hFFFF));
    script.push_back(write_row(REG_DRIVE_VOLTAGE, 16'hFFFF));
    script.push_back(tick_row(32'h0000_0304));
    script.push_back(tick_row(32'h0007_A424));
    // full forward speed, sixteen pole pairs
    script.push_back(write_row(REG_TARGET_VELOCITY, 16'h7FFF));
    script.push_back(write_row(REG_POLE_PAIR_COUNT, 16'd16));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'h8000));
    script.push_back(write_row(REG_DRIVE_VOLTAGE, 16'd40000));
    script.push_back(write_row(REG_SUPPLY_VOLTAGE, 16'd50000));
    script.push_back(tick_row(32'h0007_A425));
    script.push_back(tick_row(32'h0008_0000));
    script.push_back(tick_row(32'hFFFF_FFFF));
    script.push_back(tick_row(32'h0000_0000));
    script.push_back(tick_row(32'h8000_0000));
    // pole count beyond sixteen, slow reverse speed
    script.push_back(write_row(REG_POLE_PAIR_COUNT, 16'd17));
    script.push_back(write_row(REG_TARGET_VELOCITY, 16'hFF00));
    script.push_back(write_row(REG_ZERO_OFFSET, 16'h1234));
    script.push_back(write_row(REG_DRIVE_VOLTAGE, 16'd6300));
    script.push_back(write_row(REG_SUPPLY_VOLTAGE, 16'd12600));
    script.push_back(tick_row(32'h8000_0001));
    script.push_back(tick_row(32'h8000_03E9));
    script.push_back(tick_row(32'h8000_07D1));

    // reset held from time zero and released only once
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, light idling on both sides
    gap_pct   = 25;
    stall_pct = 25;
    prev_kind = ROW_WRITE;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        if (prev_kind == ROW_TICK) wait_idle(SETTLE_CYCLES);
        write_reg(script[i].reg_idx, script[i].value[15:0]);
      end else begin
        send_tick(script[i].value, script[i].pinned, script[i].pinned_res);
        if ($urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 12));
      end
      prev_kind = script[i].kind;
    end

    // random phases, each with its own settings and idling mix
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      shuffle_settings();
      case (phase)
        0: begin gap_pct = 30; stall_pct = 30; end
        1: begin gap_pct = 0;  stall_pct = 50; end
        2: begin gap_pct = 50; stall_pct = 0;  end
        3: begin gap_pct = 20; stall_pct = 70; end
        4: begin gap_pct = 0;  stall_pct = 0;  end   // stretch with no idling
        default: begin gap_pct = 60; stall_pct = 40; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender holds off mid-phase until the pipe is empty
        if (phase == 1 && n == PHASE_ITEMS / 2) wait_idle(0);
        send_tick(next_stamp(last_stamp), 1'b0, '0);
        if ($urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 12));
      end
    end

    // closing stretch at full rate, velocity and voltages back at the reset settings
    wait_idle(SETTLE_CYCLES);
    write_reg(REG_TARGET_VELOCITY, RST_TARGET_VELOCITY);
    write_reg(REG_DRIVE_VOLTAGE, RST_DRIVE_VOLTAGE);
    write_reg(REG_SUPPLY_VOLTAGE, RST_SUPPLY_VOLTAGE);
    write_reg(REG_ZERO_OFFSET, $urandom());
    write_reg(REG_POLE_PAIR_COUNT, {11'h000, 5'($urandom_range(1, 16))});
    calm      = 1'b1;
    gap_pct   = 0;
    stall_pct = 0;
    for (int n = 0; n < CALM_ITEMS; n++)
      send_tick(next_stamp(last_stamp), 1'b0, '0);

    // drain, then wait twice the settle time to catch stray result items
    wait_idle(2 * SETTLE_CYCLES);
    if (mismatches == 0)
      $display("open_loop_foc_sine_pwm_duty verification clean");
    else
      $display("open_loop_foc_sine_pwm_duty verification failed");
    $finish;
  end

endmodule
